FILE: src/fws_pkg.sv
// ----------------------------------------------------------------------------
// fws_pkg
// Shared sizes, operation codes and cell control for the sorted-insert queue.
// ----------------------------------------------------------------------------
package fws_pkg;

	localparam int DEPTH   = 32;
	localparam int DATA_W  = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int FUNC_W  = 2;
	localparam int VALUE_W = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_SORTED = 2'd1,
		FUNC_POP    = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	// Control broadcast to every cell for one transaction.
	typedef struct packed {
		logic ins;  // write the new word, shifting later entries back
		logic cmp;  // locate the slot by comparison (sorted insert)
		logic pop;  // shift every entry one cell toward the head
	} cell_ctl_t;

endpackage

FILE: src/fws_cell.sv
// ----------------------------------------------------------------------------
// fws_cell
// One queue slot: holds a word, compares it with the incoming word and takes
// its neighbor's word on insert or pop.
// ----------------------------------------------------------------------------
module fws_cell (
	input  logic                             clk,
	input  fws_pkg::cell_ctl_t               ctl,
	input  logic signed [fws_pkg::DATA_W-1:0] new_word,
	input  logic signed [fws_pkg::DATA_W-1:0] prev_word,
	input  logic signed [fws_pkg::DATA_W-1:0] next_word,
	input  logic                             valid,
	input  logic                             prev_valid,
	input  logic                             head_cell,
	input  logic                             hit_in,
	output logic                             hit_out,
	output logic signed [fws_pkg::DATA_W-1:0] word
);

	logic signed [fws_pkg::DATA_W-1:0] word_q;
	logic                              here;

	always_comb begin
		if (valid) begin
			here = ctl.cmp && ((word_q < new_word) || (head_cell && (word_q == new_word)));
		end else begin
			here = prev_valid;
		end
	end

	assign hit_out = hit_in | here;
	assign word    = word_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (hit_in) begin
				word_q <= prev_word;
			end else if (here) begin
				word_q <= new_word;
			end
		end else if (ctl.pop) begin
			word_q <= next_word;
		end
	end

endmodule

FILE: src/fifo_with_sorted_insert.sv
// ----------------------------------------------------------------------------
// fifo_with_sorted_insert
// Bounded queue of signed words with append, sorted insert, pop and clear.
// ----------------------------------------------------------------------------
// Operations never stall: busy stays low, a transaction is taken at
// each edge with start high, and its result appears on the next cycle with
// done high for that cycle only. The receiver cannot stall, so capture the
// result whenever done is high. Entries live in a row of shifting cells, head
// in the first cell; all cells compare against the incoming word in parallel
// and a ripple of hit flags picks the insert slot, which sets the cycle time.
// ----------------------------------------------------------------------------
module fifo_with_sorted_insert (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [fws_pkg::FUNC_W-1:0]          func,
	input  logic signed [fws_pkg::VALUE_W-1:0]  value,
	output logic                               done,
	output logic                               ok,
	output logic signed [fws_pkg::VALUE_W-1:0]  popped,
	output logic [fws_pkg::CNT_W-1:0]           count,
	output logic                               is_empty,
	output logic                               is_full
);

	fws_pkg::func_t                     op;
	fws_pkg::cell_ctl_t                 ctl;
	logic signed [fws_pkg::DATA_W-1:0]  new_word;
	logic signed [fws_pkg::DATA_W-1:0]  words [fws_pkg::DEPTH];
	logic [fws_pkg::DEPTH-1:0]          valid;
	logic [fws_pkg::DEPTH-1:0]          hit;
	logic [fws_pkg::CNT_W-1:0]          cnt_q;
	logic                               full;
	logic                               empty;
	logic                               accept;
	logic                               op_ok;
	logic                               done_q;
	logic                               ok_q;
	logic signed [fws_pkg::VALUE_W-1:0] popped_q;

	assign accept   = start & ~busy;
	assign busy     = 1'b0;
	assign op       = fws_pkg::func_t'(func);
	assign new_word = fws_pkg::DATA_W'(value);
	assign full     = (cnt_q == fws_pkg::CNT_W'(fws_pkg::DEPTH));
	assign empty    = (cnt_q == '0);

	always_comb begin
		ctl   = '0;
		op_ok = 1'b0;
		case (op)
			fws_pkg::FUNC_APPEND: begin
				op_ok   = ~full;
				ctl.ins = accept & ~full;
			end
			fws_pkg::FUNC_SORTED: begin
				op_ok   = ~full;
				ctl.ins = accept & ~full;
				ctl.cmp = 1'b1;
			end
			fws_pkg::FUNC_POP: begin
				op_ok   = ~empty;
				ctl.pop = accept & ~empty;
			end
			fws_pkg::FUNC_CLEAR: begin
				op_ok = ~empty;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	for (genvar i = 0; i < fws_pkg::DEPTH; i++) begin : g_cell
		logic signed [fws_pkg::DATA_W-1:0] prev_word;
		logic signed [fws_pkg::DATA_W-1:0] next_word;
		logic                              prev_valid;
		logic                              hit_in;

		assign valid[i] = (cnt_q > fws_pkg::CNT_W'(i));

		if (i == 0) begin : g_first
			assign prev_word  = new_word;
			assign prev_valid = 1'b1;
			assign hit_in     = 1'b0;
		end else begin : g_rest
			assign prev_word  = words[i-1];
			assign prev_valid = valid[i-1];
			assign hit_in     = hit[i-1];
		end

		if (i == fws_pkg::DEPTH - 1) begin : g_last
			assign next_word = words[i];
		end else begin : g_inner
			assign next_word = words[i+1];
		end

		fws_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_word   (new_word),
			.prev_word  (prev_word),
			.next_word  (next_word),
			.valid      (valid[i]),
			.prev_valid (prev_valid),
			.head_cell  (i == 0),
			.hit_in     (hit_in),
			.hit_out    (hit[i]),
			.word       (words[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctl.pop) begin
				cnt_q <= cnt_q - 1'b1;
			end else if (accept && (op == fws_pkg::FUNC_CLEAR)) begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q <= op_ok;
			if (ctl.pop) begin
				popped_q <= fws_pkg::VALUE_W'(words[0]);
			end else begin
				popped_q <= '0;
			end
		end
	end

	assign done     = done_q;
	assign ok       = ok_q;
	assign popped   = popped_q;
	assign count    = cnt_q;
	assign is_empty = empty;
	assign is_full  = full;

endmodule
